>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Every macro samples on clk_i and is
// disabled while rst_ni is low, so only use it where those names exist.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define SMNF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define SMNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/smnf_pkg.sv
// ----------------------------------------------------------------------------
// smnf_pkg
// Shared constants, register map and control types of the sliding-minimum
// noise floor estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package smnf_pkg;

  // Default sizes
  localparam int LONG_LEN_DEF    = 200;
  localparam int SHORT_LEN_DEF   = 50;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int IN_W      = 16;
  localparam int NP_W      = 16;
  localparam int ZM_W      = 20;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  // Zero-mean output saturation bounds (Q4.15)
  localparam int ZM_MAX = 524287;
  localparam int ZM_MIN = -524288;

  // Fraction bits of the scaling registers
  localparam int AVG_SH = 16;  // avg_rate, Q0.16
  localparam int NS_SH  = 16;  // noise_scale, Q0.16
  localparam int SG_SH  = 12;  // sub_gain, Q4.12
  localparam int OG_SH  = 12;  // out_gain, Q4.12

  // Average reset value, 0.05 in Q1.15, rescaled to the sample format
  localparam int AVG_RESET_Q15 = 1638;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AVG_RATE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SUB_GAIN    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SUB_OFFSET  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN    = CFG_IDX_W'(5);

  typedef struct packed {
    logic [CFG_W-1:0] avg_rate;
    logic [CFG_W-1:0] noise_scale;
    logic [CFG_W-1:0] noise_floor;
    logic [CFG_W-1:0] sub_gain;
    logic [CFG_W-1:0] sub_offset;
    logic [CFG_W-1:0] out_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    avg_rate:    16'd262,
    noise_scale: 16'd19661,
    noise_floor: 16'd164,
    sub_gain:    16'd9830,
    sub_offset:  16'd1638,
    out_gain:    16'd4506
  };

  // Controller to datapath commands, at most one active per cycle
  typedef struct packed {
    logic load;      // latch word, advance positions and fill counts
    logic write;     // store sample into both windows, seed minima
    logic scan;      // issue one window read
    logic avg_mul;   // (min - avg) * avg_rate
    logic avg_upd;   // update running average
    logic np_mul;    // avg * noise_scale
    logic term_mul;  // finish noise power, avg * sub_gain
    logic d_calc;    // sample - term - offset
    logic z_mul;     // d * out_gain
    logic out_load;  // load output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/smnf_if.sv
// ----------------------------------------------------------------------------
// smnf_if
// Valid/ready channels of the noise floor estimator: sample words in,
// noise power and zero-mean signal words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smnf_in_if;
  logic                        valid;
  logic                        ready;
  logic [smnf_pkg::IN_W-1:0]   sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smnf_out_if;
  logic                             valid;
  logic                             ready;
  logic        [smnf_pkg::NP_W-1:0] noise_power;
  logic signed [smnf_pkg::ZM_W-1:0] zero_mean_signal;

  modport source (output valid, output noise_power, output zero_mean_signal, input ready);
  modport sink   (input valid, input noise_power, input zero_mean_signal, output ready);
endinterface

`default_nettype wire

>>> rtl/core/smnf_ram.sv
// ----------------------------------------------------------------------------
// smnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smnf_ram #(
  parameter int WIDTH = smnf_pkg::SAMPLE_BITS_DEF,
  parameter int DEPTH = smnf_pkg::LONG_LEN_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smnf_ctrl.sv
// ----------------------------------------------------------------------------
// smnf_ctrl
// Sequencer of the noise floor estimator: store, window scan, then the
// multiply steps on the shared multiplier, then result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module smnf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire smnf_pkg::sts_t sts_i,
  output smnf_pkg::cmd_t      cmd_o
);
  import smnf_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_WRITE    = 11'b000_0000_0010,
    S_SCAN     = 11'b000_0000_0100,
    S_DRAIN    = 11'b000_0000_1000,
    S_AVG_MUL  = 11'b000_0001_0000,
    S_AVG_UPD  = 11'b000_0010_0000,
    S_NP_MUL   = 11'b000_0100_0000,
    S_TERM_MUL = 11'b000_1000_0000,
    S_D_CALC   = 11'b001_0000_0000,
    S_Z_MUL    = 11'b010_0000_0000,
    S_DONE     = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // last read word is compared here
      S_DRAIN: begin
        state_d = S_AVG_MUL;
      end
      S_AVG_MUL: begin
        cmd_o.avg_mul = 1'b1;
        state_d       = S_AVG_UPD;
      end
      S_AVG_UPD: begin
        cmd_o.avg_upd = 1'b1;
        state_d       = S_NP_MUL;
      end
      S_NP_MUL: begin
        cmd_o.np_mul = 1'b1;
        state_d      = S_TERM_MUL;
      end
      S_TERM_MUL: begin
        cmd_o.term_mul = 1'b1;
        state_d        = S_D_CALC;
      end
      S_D_CALC: begin
        cmd_o.d_calc = 1'b1;
        state_d      = S_Z_MUL;
      end
      S_Z_MUL: begin
        cmd_o.z_mul = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/smnf_dp.sv
// ----------------------------------------------------------------------------
// smnf_dp
// Datapath of the noise floor estimator: window memories with serial min
// scan, running average, shared multiplier and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module smnf_dp #(
  parameter int LONG_LEN    = smnf_pkg::LONG_LEN_DEF,
  parameter int SHORT_LEN   = smnf_pkg::SHORT_LEN_DEF,
  parameter int SAMPLE_BITS = smnf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire smnf_pkg::cmd_t                   cmd_i,
  output smnf_pkg::sts_t                        sts_o,
  input  wire smnf_pkg::cfg_t                   cfg_i,
  input  wire logic [smnf_pkg::IN_W-1:0]        sample_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [smnf_pkg::NP_W-1:0]             noise_power_o,
  output logic signed [smnf_pkg::ZM_W-1:0]      zero_mean_signal_o
);
  import smnf_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int SIN_W  = (SB < IN_W) ? SB : IN_W;
  localparam int LAW    = $clog2(LONG_LEN);
  localparam int SAW    = $clog2(SHORT_LEN);
  localparam int LFW    = $clog2(LONG_LEN + 1);
  localparam int SFW    = $clog2(SHORT_LEN + 1);
  localparam int MAXLEN = (LONG_LEN > SHORT_LEN) ? LONG_LEN : SHORT_LEN;
  localparam int IW     = $clog2(MAXLEN);
  localparam int CW     = $clog2(MAXLEN + 1);
  // d = sample - term - offset, term up to SB+5 bits
  localparam int DW     = (((SB + 5) > CFG_W) ? (SB + 5) : CFG_W) + 2;
  localparam int MA     = DW;
  localparam int PW     = MA + CFG_W + 1;

  localparam logic [SB-1:0] ONE_VAL = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB-1:0] SMASK   = '1;
  localparam logic [63:0]   AVG_RST_W =
    (((64'd1 << (SB - 1)) * 64'(AVG_RESET_Q15)) + (64'd1 << 14)) >> 15;
  localparam logic [SB-1:0] AVG_RST = SB'(AVG_RST_W);

  localparam logic signed [PW:0]   RND16  = (PW+1)'(1 << (AVG_SH - 1));
  localparam logic signed [PW:0]   RND12  = (PW+1)'(1 << (SG_SH - 1));
  localparam logic signed [PW:0]   NP_HI  = (PW+1)'(65535);
  localparam logic signed [PW:0]   ZMAX_X = (PW+1)'(ZM_MAX);
  localparam logic signed [PW:0]   ZMIN_X = (PW+1)'(ZM_MIN);
  localparam logic signed [PW+1:0] AVG_HI = $signed((PW+2)'(SMASK));

  // Item and window state
  logic [SB-1:0]  s_q;
  logic           store_q;
  logic [LAW-1:0] lpos_q;
  logic [SAW-1:0] spos_q;
  logic [LFW-1:0] lfill_q;
  logic [SFW-1:0] sfill_q;
  logic           lw0_q, lw1_q, sw0_q, sw1_q;  // entries 0/1 written since reset
  logic [SB-1:0]  lmin_q, smin_q;
  logic [SB-1:0]  avg_q;

  // Scan pipeline
  logic [IW-1:0]  idx_q, rd_idx_q;
  logic           rd_l_q, rd_s_q;
  logic [CW-1:0]  lf_x, sf_x, scan_max;
  logic           ren_l, ren_s;
  logic [SB-1:0]  lrdata, srdata, lval, sval;

  // Arithmetic
  logic signed [SB:0]     diff;
  logic signed [MA-1:0]   mul_a;
  logic signed [CFG_W:0]  mul_b;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   p_q;
  logic signed [PW:0]     p_ext, r16, r12;
  logic signed [PW+1:0]   avg_sum;
  logic [SB-1:0]          avg_d;
  logic [NP_W-1:0]        np_d, np_q;
  logic signed [MA-1:0]   d_d, d_q;
  logic signed [ZM_W-1:0] zm_d;
  logic [SB-1:0]          min_m;

  // Output register
  logic                   out_valid_q;
  logic [NP_W-1:0]        out_np_q;
  logic signed [ZM_W-1:0] out_zm_q;

  // --------------------------------------------------------------------------
  // Window memories
  // --------------------------------------------------------------------------
  smnf_ram #(.WIDTH(SB), .DEPTH(LONG_LEN)) u_long_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && store_q),
    .waddr_i (lpos_q),
    .wdata_i (s_q),
    .re_i    (ren_l),
    .raddr_i (idx_q[LAW-1:0]),
    .rdata_o (lrdata)
  );

  smnf_ram #(.WIDTH(SB), .DEPTH(SHORT_LEN)) u_short_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write && store_q),
    .waddr_i (spos_q),
    .wdata_i (s_q),
    .re_i    (ren_s),
    .raddr_i (idx_q[SAW-1:0]),
    .rdata_o (srdata)
  );

  // Scan control: index 0 .. max(fill)-1, each window reads below its fill
  assign lf_x     = CW'(lfill_q);
  assign sf_x     = CW'(sfill_q);
  assign scan_max = (lf_x > sf_x) ? lf_x : sf_x;
  assign ren_l    = cmd_i.scan && (CW'(idx_q) < lf_x);
  assign ren_s    = cmd_i.scan && (CW'(idx_q) < sf_x);

  assign sts_o.scan_last = (CW'(idx_q) == (scan_max - CW'(1)));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Entries 0 and 1 hold 1.0 until the write position wraps onto them
  assign lval = (((rd_idx_q == '0) && !lw0_q) || ((rd_idx_q == IW'(1)) && !lw1_q)) ?
                ONE_VAL : lrdata;
  assign sval = (((rd_idx_q == '0) && !sw0_q) || ((rd_idx_q == IW'(1)) && !sw1_q)) ?
                ONE_VAL : srdata;

  // --------------------------------------------------------------------------
  // Window state, minima and scan registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= 1'b0;
      lpos_q  <= '0;
      spos_q  <= '0;
      lfill_q <= LFW'(1);
      sfill_q <= SFW'(1);
      lw0_q   <= 1'b0;
      lw1_q   <= 1'b0;
      sw0_q   <= 1'b0;
      sw1_q   <= 1'b0;
      lmin_q  <= ONE_VAL;
      smin_q  <= ONE_VAL;
      rd_l_q  <= 1'b0;
      rd_s_q  <= 1'b0;
    end else begin
      rd_l_q <= ren_l;
      rd_s_q <= ren_s;
      if (cmd_i.load) begin
        store_q <= (sfill_q >= SFW'(2));
        lpos_q  <= (lpos_q == LAW'(LONG_LEN - 1)) ? '0 : lpos_q + LAW'(1);
        spos_q  <= (spos_q == SAW'(SHORT_LEN - 1)) ? '0 : spos_q + SAW'(1);
        if (lfill_q < LFW'(LONG_LEN)) begin
          lfill_q <= lfill_q + LFW'(1);
        end
        if (sfill_q < SFW'(SHORT_LEN)) begin
          sfill_q <= sfill_q + SFW'(1);
        end
      end
      if (cmd_i.write && store_q) begin
        lmin_q <= s_q;
        smin_q <= s_q;
        if (lpos_q == '0)      lw0_q <= 1'b1;
        if (lpos_q == LAW'(1)) lw1_q <= 1'b1;
        if (spos_q == '0)      sw0_q <= 1'b1;
        if (spos_q == SAW'(1)) sw1_q <= 1'b1;
      end
      // running minimum over words returned by the memories
      if (rd_l_q && (lval <= lmin_q)) begin
        lmin_q <= lval;
      end
      if (rd_s_q && (sval <= smin_q)) begin
        smin_q <= sval;
      end
    end
  end

  // Payload registers of the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      s_q <= SB'(sample_i[SIN_W-1:0]);
    end
    if (cmd_i.write) begin
      idx_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + IW'(1);
    end
    rd_idx_q <= idx_q;
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  assign min_m = (smin_q < lmin_q) ? smin_q : lmin_q;
  assign diff  = $signed({1'b0, min_m}) - $signed({1'b0, avg_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.avg_mul) begin
      mul_a = MA'(diff);
      mul_b = $signed({1'b0, cfg_i.avg_rate});
    end else if (cmd_i.np_mul) begin
      mul_a = MA'($signed({1'b0, avg_q}));
      mul_b = $signed({1'b0, cfg_i.noise_scale});
    end else if (cmd_i.term_mul) begin
      mul_a = MA'($signed({1'b0, avg_q}));
      mul_b = $signed({1'b0, cfg_i.sub_gain});
    end else if (cmd_i.z_mul) begin
      mul_a = d_q;
      mul_b = $signed({1'b0, cfg_i.out_gain});
    end
  end

  assign prod = mul_a * mul_b;

  // Round half up, as a floor shift after adding half an LSB
  assign p_ext = (PW+1)'(p_q);
  assign r16   = (p_ext + RND16) >>> AVG_SH;
  assign r12   = (p_ext + RND12) >>> SG_SH;

  // Average update with clamp to the sample range
  assign avg_sum = (PW+2)'($signed({1'b0, avg_q})) + (PW+2)'(r16);
  always_comb begin
    if (avg_sum < 0) begin
      avg_d = '0;
    end else if (avg_sum > AVG_HI) begin
      avg_d = SMASK;
    end else begin
      avg_d = SB'(avg_sum);
    end
  end

  // Noise power: raise to floor, saturate to 16 bits
  always_comb begin
    if (r16 < $signed((PW+1)'(cfg_i.noise_floor))) begin
      np_d = cfg_i.noise_floor;
    end else if (r16 > NP_HI) begin
      np_d = '1;
    end else begin
      np_d = r16[NP_W-1:0];
    end
  end

  // Difference: sample - round(avg * sub_gain) - offset
  assign d_d = MA'($signed({1'b0, s_q})) - MA'(r12) - MA'($signed({1'b0, cfg_i.sub_offset}));

  // Zero-mean signal saturation
  always_comb begin
    if (r12 > ZMAX_X) begin
      zm_d = ZM_W'(ZM_MAX);
    end else if (r12 < ZMIN_X) begin
      zm_d = ZM_W'(ZM_MIN);
    end else begin
      zm_d = r12[ZM_W-1:0];
    end
  end

  // Arithmetic payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_mul || cmd_i.np_mul || cmd_i.term_mul || cmd_i.z_mul) begin
      p_q <= prod;
    end
    if (cmd_i.term_mul) begin
      np_q <= np_d;
    end
    if (cmd_i.d_calc) begin
      d_q <= d_d;
    end
    if (cmd_i.out_load) begin
      out_np_q <= np_q;
      out_zm_q <= zm_d;
    end
  end

  // Running average
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= AVG_RST;
    end else if (cmd_i.avg_upd) begin
      avg_q <= avg_d;
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign noise_power_o      = out_np_q;
  assign zero_mean_signal_o = out_zm_q;

endmodule

`default_nettype wire

>>> rtl/core/sliding_min_noise_floor.sv
// The serial scan of the window memories reads one entry per cycle over
//   max(long fill, short fill) entries, at most max(LONG_LEN, SHORT_LEN).
// A new sample word is accepted only in idle, after the previous result
//   word has been loaded into the output register.
// Reset: asynchronous, active low. No clearing pass; unwritten window
//   entries read as 1.0 through the fill counts and the written flags of entries 0 and 1.
// ----------------------------------------------------------------------------
// sliding_min_noise_floor
// Minimum-statistics noise floor estimator: sliding minimum over a long and
// a short window, exponential average, noise power and zero-mean signal.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sliding_min_noise_floor #(
  parameter int LONG_LEN    = smnf_pkg::LONG_LEN_DEF,
  parameter int SHORT_LEN   = smnf_pkg::SHORT_LEN_DEF,
  parameter int SAMPLE_BITS = smnf_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  smnf_in_if.sink                                 in_ch,
  smnf_out_if.source                              out_ch,
  input  wire logic                               cfg_we_i,
  input  wire logic [smnf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [smnf_pkg::CFG_W-1:0]         cfg_wdata_i
);
  import smnf_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;

  // Configuration register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AVG_RATE:    cfg_d.avg_rate    = cfg_wdata_i;
        REG_NOISE_SCALE: cfg_d.noise_scale = cfg_wdata_i;
        REG_NOISE_FLOOR: cfg_d.noise_floor = cfg_wdata_i;
        REG_SUB_GAIN:    cfg_d.sub_gain    = cfg_wdata_i;
        REG_SUB_OFFSET:  cfg_d.sub_offset  = cfg_wdata_i;
        REG_OUT_GAIN:    cfg_d.out_gain    = cfg_wdata_i;
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Controller
  smnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  smnf_dp #(
    .LONG_LEN    (LONG_LEN),
    .SHORT_LEN   (SHORT_LEN),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_i              (cfg_q),
    .sample_i           (in_ch.sample),
    .out_ready_i        (out_ch.ready),
    .out_valid_o        (out_ch.valid),
    .noise_power_o      (out_ch.noise_power),
    .zero_mean_signal_o (out_ch.zero_mean_signal)
  );

  // Checks
  `SMNF_ASSERT(a_cmd_exclusive, $onehot0(cmd), "more than one datapath command active")
  `SMNF_ASSERT(a_no_overwrite, !cmd.out_load || sts.out_free, "result word overwritten")
  `SMNF_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
                    "input taken while busy")
  `SMNF_ASSERT_NEXT(a_result_shown, cmd.out_load, out_ch.valid, "loaded result not presented")

endmodule

`default_nettype wire
